FILE: rtl/bl5_pkg.sv
// Shared widths, constants and pipeline types for the RGB555 in-place blur.
package bl5_pkg;

  // Pixel and channel geometry
  localparam int unsigned PIX_W    = 15;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned CH_W     = 5;
  localparam int unsigned CH_N     = 3;

  // Line width register
  localparam int unsigned LW_W     = 12;
  localparam int unsigned MAX_LINE = 2048;
  localparam int unsigned MIN_LINE = 4;
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);

  // Original-pixel ring: one line plus three pixels
  localparam int unsigned DLY_DEPTH = MAX_LINE + 3;
  localparam int unsigned DLY_AW    = $clog2(DLY_DEPTH);

  // Blurred-line ring
  localparam int unsigned LINE_AW  = $clog2(MAX_LINE);

  // Pixel position counter, saturating
  localparam int unsigned POS_W    = 32;

  // Control carried from the address stage into the compute stage
  typedef struct packed {
    logic               up_en;
    logic               left_en;
    logic               left_blur;
    logic [PIX_W-1:0]   down;
    logic [LINE_AW-1:0] line_addr;
  } s1_ctrl_t;

endpackage

FILE: rtl/bl5_ifs.sv
// Valid/ready stream interfaces for the pixel input and the blurred output.
interface bl5_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [bl5_pkg::IN_W-1:0]  pixel_in;
  logic                      frame_start;
  logic                      flush;

  modport source (output valid, output pixel_in, output frame_start, output flush,
                  input ready);
  modport sink   (input valid, input pixel_in, input frame_start, input flush,
                  output ready);
endinterface

interface bl5_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [bl5_pkg::PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

FILE: rtl/bl5_delay_mem.sv
// Original-pixel ring RAM: each entry holds a pixel and its predecessor, two read ports.
module bl5_delay_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bl5_pkg::DLY_AW-1:0]    waddr_i,
  input  logic [2*bl5_pkg::PIX_W-1:0]   wdata_i,
  input  logic [bl5_pkg::DLY_AW-1:0]    raddr_a_i,
  input  logic [bl5_pkg::DLY_AW-1:0]    raddr_b_i,
  output logic [2*bl5_pkg::PIX_W-1:0]   rdata_a_o,
  output logic [bl5_pkg::PIX_W-1:0]     rdata_b_o
);
  import bl5_pkg::*;

  logic [2*PIX_W-1:0] mem [DLY_DEPTH];
  logic [2*PIX_W-1:0] rdata_a_q;
  logic [PIX_W-1:0]   rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports; port B only needs the older pixel of the pair
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i][2*PIX_W-1:PIX_W];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/bl5_line_mem.sv
// Blurred-line ring RAM: one write port, one registered read port.
module bl5_line_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [bl5_pkg::LINE_AW-1:0]  waddr_i,
  input  logic [bl5_pkg::PIX_W-1:0]    wdata_i,
  input  logic [bl5_pkg::LINE_AW-1:0]  raddr_i,
  output logic [bl5_pkg::PIX_W-1:0]    rdata_o
);
  import bl5_pkg::*;

  logic [PIX_W-1:0] mem [MAX_LINE];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bl5_calc.sv
// Compute stage: neighbor selection, per-channel five-point blur, last-result register.
module bl5_calc (
  input  logic                       clk_i,
  input  logic                       valid_i,
  input  bl5_pkg::s1_ctrl_t          ctrl_i,
  input  logic [2*bl5_pkg::PIX_W-1:0] pair_i,
  input  logic [bl5_pkg::PIX_W-1:0]  left_orig_i,
  input  logic [bl5_pkg::PIX_W-1:0]  up_raw_i,
  output logic [bl5_pkg::PIX_W-1:0]  res_o
);
  import bl5_pkg::*;

  logic [PIX_W-1:0] last_q;
  logic [PIX_W-1:0] cur;
  logic [PIX_W-1:0] right;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] left;
  logic [PIX_W-1:0] res;
  logic [CH_W+2:0]  sum [CH_N];

  // Pair read at the right neighbor: older half is the center pixel
  assign cur   = pair_i[2*PIX_W-1:PIX_W];
  assign right = pair_i[PIX_W-1:0];

  // Out-of-frame neighbors read as zero; left switches to blurred at group starts
  always_comb begin
    up   = ctrl_i.up_en ? up_raw_i : '0;
    left = '0;
    if (ctrl_i.left_en) begin
      left = ctrl_i.left_blur ? last_q : left_orig_i;
    end
  end

  // (up + down + left + right + 4*center) >> 3 per channel; max 248, no overflow
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      sum[c] = (CH_W+3)'(up[c*CH_W +: CH_W])
             + (CH_W+3)'(ctrl_i.down[c*CH_W +: CH_W])
             + (CH_W+3)'(left[c*CH_W +: CH_W])
             + (CH_W+3)'(right[c*CH_W +: CH_W])
             + {1'b0, cur[c*CH_W +: CH_W], 2'b00};
      res[c*CH_W +: CH_W] = sum[c][CH_W+2:3];
    end
  end

  // Most recent blurred pixel, used as left at group-of-four starts
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      last_q <= res;
    end
  end

  assign res_o = res;

endmodule

FILE: rtl/bl5_out_fifo.sv
// Three-entry output queue; reports room for one more item in flight.
module bl5_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [bl5_pkg::PIX_W-1:0] data_i,
  input  logic                      pending_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [bl5_pkg::PIX_W-1:0] data_o
);
  import bl5_pkg::*;

  localparam int unsigned DEPTH = 3;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [PIX_W-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pop;
  logic [CW:0]      used;

  assign pop     = valid_o & ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

  // Room counts the item already in the compute stage
  assign used   = {1'b0, count_q} + (CW+1)'(pending_i);
  assign room_o = (used < (CW+1)'(DEPTH));

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/inplace_five_point_blur_rgb555_top.sv
// In-place five-point RGB555 blur: line-width register, address stage, RAMs and output queue.
//
// Accepts one pixel per clock while the output queue has room and returns one blurred
// pixel per accepted item once the lag of one line plus one pixel has filled; flush items
// push the tail out. The rate is set by the original-pixel RAM, which stores each pixel
// paired with its predecessor so that its two read ports supply center, right and left
// together, and by the blurred-line RAM with one read and one write a cycle.
// Each accepted request is registered into the compute stage, and its result is pushed
// into the three-entry queue, which keeps input moving while the output side briefly stalls.
// Neither RAM needs clearing after reset: every read is gated by the position
// since frame start. The line width may be changed between requests.
module inplace_five_point_blur_rgb555_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bl5_pkg::LW_W-1:0]   cfg_wdata_i,
  bl5_pix_in_if.sink                 pix_in_i,
  bl5_pix_out_if.source              pix_out_o
);
  import bl5_pkg::*;

  logic [LW_W-1:0]    width_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [DLY_AW-1:0]  in_ptr_q, in_ptr_d;
  logic [LINE_AW-1:0] out_ptr_q, out_ptr_d;
  logic [PIX_W-1:0]   prev_pix_q;
  logic               s1_valid_q;
  s1_ctrl_t           s1_ctrl_q, s1_ctrl_d;

  logic               accept;
  logic               room;
  logic [PIX_W-1:0]   pix;
  logic [POS_W-1:0]   n;
  logic [DLY_AW-1:0]  iptr;
  logic [LINE_AW-1:0] optr;
  logic               has_res;
  logic [1:0]         phase;
  logic [DLY_AW:0]    diff_a, diff_b;
  logic [DLY_AW-1:0]  raddr_a, raddr_b;
  logic [LINE_AW-1:0] line_raddr;

  logic [2*PIX_W-1:0] pair_rd;
  logic [PIX_W-1:0]   left_rd;
  logic [PIX_W-1:0]   up_rd;
  logic [PIX_W-1:0]   res;

  // Line width register, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= LW_RESET;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < LW_W'(MIN_LINE)) begin
        width_q <= LW_W'(MIN_LINE);
      end else if (cfg_wdata_i > LW_W'(MAX_LINE)) begin
        width_q <= LW_W'(MAX_LINE);
      end else begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  assign accept         = pix_in_i.valid & pix_in_i.ready;
  assign pix_in_i.ready = room;

  // Frame start restarts position and both ring pointers for this request
  assign pix  = pix_in_i.flush ? '0 : pix_in_i.pixel_in[PIX_W-1:0];
  assign n    = pix_in_i.frame_start ? '0 : pos_q;
  assign iptr = pix_in_i.frame_start ? '0 : in_ptr_q;
  assign optr = pix_in_i.frame_start ? '0 : out_ptr_q;

  // Gating by position: p = n - w - 1 is the pixel whose result leaves now
  assign has_res = (n > POS_W'(width_q));
  assign phase   = n[1:0] - width_q[1:0] - 2'd1;

  always_comb begin
    s1_ctrl_d.up_en     = (n > POS_W'({width_q, 1'b0}));
    s1_ctrl_d.left_en   = (n > POS_W'(width_q) + POS_W'(1));
    s1_ctrl_d.left_blur = (phase == 2'd0);
    s1_ctrl_d.down      = prev_pix_q;
    s1_ctrl_d.line_addr = optr;
  end

  // Ring addresses: pair at back w gives center/right, at back w+1 gives left
  always_comb begin
    diff_a  = {1'b0, iptr} - (DLY_AW+1)'(width_q);
    diff_b  = {1'b0, iptr} - (DLY_AW+1)'(width_q) - (DLY_AW+1)'(1);
    raddr_a = diff_a[DLY_AW] ? DLY_AW'(diff_a + (DLY_AW+1)'(DLY_DEPTH)) : diff_a[DLY_AW-1:0];
    raddr_b = diff_b[DLY_AW] ? DLY_AW'(diff_b + (DLY_AW+1)'(DLY_DEPTH)) : diff_b[DLY_AW-1:0];
  end

  assign line_raddr = optr - width_q[LINE_AW-1:0];

  // Next position and pointers
  always_comb begin
    pos_d     = (n == '1) ? n : n + POS_W'(1);
    in_ptr_d  = (iptr == DLY_AW'(DLY_DEPTH - 1)) ? '0 : iptr + DLY_AW'(1);
    out_ptr_d = has_res ? optr + LINE_AW'(1) : optr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_ptr_q   <= '0;
      out_ptr_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept & has_res;
      if (accept) begin
        pos_q     <= pos_d;
        in_ptr_q  <= in_ptr_d;
        out_ptr_q <= out_ptr_d;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    s1_ctrl_q <= s1_ctrl_d;
    if (accept) begin
      prev_pix_q <= pix;
    end
  end

  bl5_delay_mem u_delay_mem (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (iptr),
    .wdata_i   ({prev_pix_q, pix}),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (pair_rd),
    .rdata_b_o (left_rd)
  );

  bl5_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_ctrl_q.line_addr),
    .wdata_i (res),
    .raddr_i (line_raddr),
    .rdata_o (up_rd)
  );

  bl5_calc u_calc (
    .clk_i       (clk_i),
    .valid_i     (s1_valid_q),
    .ctrl_i      (s1_ctrl_q),
    .pair_i      (pair_rd),
    .left_orig_i (left_rd),
    .up_raw_i    (up_rd),
    .res_o       (res)
  );

  bl5_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (s1_valid_q),
    .data_i    (res),
    .pending_i (s1_valid_q),
    .room_o    (room),
    .valid_o   (pix_out_o.valid),
    .ready_i   (pix_out_o.ready),
    .data_o    (pix_out_o.pixel_out)
  );

endmodule

FILE: bench/blur555_checker.sv
// Watches the pixel streams of the RGB555 blur, predicts each blurred pixel and compares.
`timescale 1ns / 1ps

module blur555_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bl5_pkg::LW_W-1:0] cfg_wdata_i,
  bl5_pix_in_if                    pix_in_mon,
  bl5_pix_out_if                   pix_out_mon,
  output int                       fail_count_o,
  output int                       pending_o
);
  import bl5_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Predictor state: original pixels, blurred line, frame position
  logic [LW_W-1:0]    width_reg;
  logic [PIX_W-1:0]   orig_ring [DLY_DEPTH];
  logic [PIX_W-1:0]   blur_ring [MAX_LINE];
  logic [POS_W-1:0]   frame_pos;
  logic [PIX_W-1:0]   prev_blur;
  int unsigned        orig_wp;
  int unsigned        blur_wp;
  logic [PIX_W-1:0]   blurred_due [$];
  int                 fails;

  // Original pixel written 'back' requests ago
  function automatic logic [PIX_W-1:0] orig_back(int unsigned back);
    return orig_ring[(orig_wp + DLY_DEPTH - back) % DLY_DEPTH];
  endfunction

  // Advance the in-place blur by one request; queue the pixel it releases, if any
  task automatic blur_next_pixel(input logic [IN_W-1:0] raw, input logic sof, input logic pad);
    int unsigned      w;
    int unsigned      p;
    int unsigned      sum;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] res;
    // out-of-range widths are clamped, odd widths used as they are
    w = (width_reg < MIN_LINE) ? MIN_LINE : (width_reg > MAX_LINE) ? MAX_LINE : width_reg;
    pix = pad ? '0 : raw[PIX_W-1:0];
    if (sof) begin
      frame_pos = '0;
      orig_wp   = 0;
      blur_wp   = 0;
      prev_blur = '0;
    end
    orig_ring[orig_wp] = pix;
    if (frame_pos >= w + 1) begin
      p     = frame_pos - w - 1;
      cur   = orig_back(w + 1);
      right = orig_back(w);
      down  = orig_back(1);
      up    = '0;
      left  = '0;
      // up is already blurred; left is blurred only at the start of a group of four
      if (p >= w) up = blur_ring[(blur_wp + MAX_LINE - w) % MAX_LINE];
      if (p >= 1) left = (p % 4 == 0) ? prev_blur : orig_back(w + 2);
      res = '0;
      for (int ch = 0; ch < CH_N; ch++) begin
        sum = up[ch*CH_W +: CH_W] + down[ch*CH_W +: CH_W] + left[ch*CH_W +: CH_W]
            + right[ch*CH_W +: CH_W] + 4 * cur[ch*CH_W +: CH_W];
        res[ch*CH_W +: CH_W] = sum[7:3];
      end
      blur_ring[blur_wp] = res;
      blur_wp   = (blur_wp + 1) % MAX_LINE;
      prev_blur = res;
      blurred_due.push_back(res);
    end
    orig_wp = (orig_wp + 1) % DLY_DEPTH;
    if (frame_pos != '1) frame_pos++;
  endtask

  // Config, input and output are all sampled at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = LW_RESET;
      frame_pos = '0;
      prev_blur = '0;
      orig_wp   = 0;
      blur_wp   = 0;
      fails     = 0;
      blurred_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (pix_in_mon.valid && pix_in_mon.ready)
        blur_next_pixel(pix_in_mon.pixel_in, pix_in_mon.frame_start, pix_in_mon.flush);
      if (pix_out_mon.valid && pix_out_mon.ready) begin
        if (blurred_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: pixel_out %h arrived with no pixel due", $time,
                     pix_out_mon.pixel_out);
        end else if (pix_out_mon.pixel_out !== blurred_due[0]) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: pixel_out mismatch: expected %h, got %h", $time,
                     blurred_due[0], pix_out_mon.pixel_out);
          void'(blurred_due.pop_front());
        end else begin
          void'(blurred_due.pop_front());
        end
      end
      fail_count_o <= fails;
      pending_o    <= blurred_due.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Stimulus, flow control and verdict for the RGB555 in-place blur.
`timescale 1ns / 1ps

module testbench;
  import bl5_pkg::*;

  localparam int RANDOM_ITEMS = 1100;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_BURSTY} rx_mode_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [LW_W-1:0] cfg_wdata;
  int              fail_count;
  int              due_count;
  int unsigned     burst_left;
  rx_mode_e        rx_mode;
  int unsigned     rx_mode_left;
  int unsigned     rx_stall_left;

  bl5_pix_in_if  pix_in ();
  bl5_pix_out_if pix_out ();

  inplace_five_point_blur_rgb555_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_in_i    (pix_in),
    .pix_out_o   (pix_out)
  );

  blur555_checker pixel_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pix_in_mon   (pix_in),
    .pix_out_mon  (pix_out),
    .fail_count_o (fail_count),
    .pending_o    (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: stall pattern switches between open, coin-flip, mostly open and long stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_out.ready <= 1'b0;
      rx_mode       = RX_OPEN;
      rx_mode_left  = 0;
      rx_stall_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(64, 400);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   pix_out.ready <= 1'b1;
        RX_COIN:   pix_out.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: pix_out.ready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (rx_stall_left == 0 && $urandom_range(0, 9) == 0)
            rx_stall_left = $urandom_range(1, 16);
          if (rx_stall_left != 0) begin
            pix_out.ready <= 1'b0;
            rx_stall_left--;
          end else begin
            pix_out.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic int unsigned eff_line(int unsigned raw);
    if (raw < MIN_LINE) return MIN_LINE;
    if (raw > MAX_LINE) return MAX_LINE;
    return raw;
  endfunction

  // One request; bursts of random length with random gaps in between
  task automatic send_pixel(input logic [IN_W-1:0] pix, input logic sof, input logic pad);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid       <= 1'b1;
    pix_in.pixel_in    <= pix;
    pix_in.frame_start <= sof;
    pix_in.flush       <= pad;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // Drop valid, wait for every due pixel, then cover requests that release nothing
  task automatic settle_idle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [LW_W-1:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned raw_w;
    int unsigned ew;
    int unsigned lines;
    int unsigned len;
    int unsigned grow_at;
    int unsigned cut_at;
    int unsigned pick;
    int unsigned sent;
    bit          fresh_cfg;

    pix_in.valid       <= 1'b0;
    pix_in.pixel_in    <= '0;
    pix_in.frame_start <= 1'b0;
    pix_in.flush       <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    burst_left         = 0;
    rst_n              <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: width 0 acts as the minimum of four
    write_width('0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);   // full scale, bit 15 set
    send_pixel(16'h7FFF, 1'b0, 1'b0);
    send_pixel(16'h7FFF, 1'b0, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'h8000, 1'b0, 1'b0);   // only the ignored bit
    send_pixel(16'h001F, 1'b0, 1'b0);
    send_pixel(16'h03E0, 1'b0, 1'b0);
    send_pixel(16'h7C00, 1'b0, 1'b0);
    send_pixel(16'h7FFF, 1'b0, 1'b0);
    send_pixel(16'h5555, 1'b0, 1'b0);
    send_pixel(16'h2AAA, 1'b0, 1'b0);
    // flush masks a nonzero pixel, then drains the rest of the frame
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    send_pixel(16'h1234, 1'b0, 1'b1);
    send_pixel(16'h7FFF, 1'b0, 1'b1);
    send_pixel(16'h7FFF, 1'b0, 1'b1);
    send_pixel(16'h7FFF, 1'b0, 1'b1);
    send_pixel(16'h7FFF, 1'b1, 1'b0);
    send_pixel(16'h7FFF, 1'b0, 1'b0);
    // frame restarts mid-frame, then a restart that is also a flush
    send_pixel(16'h4210, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b1);
    repeat (4) send_pixel(16'h7FFF, 1'b0, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b1);

    // Register at all ones acts as the widest line; a short frame there releases nothing
    write_width('1);
    send_pixel(IN_W'($urandom), 1'b1, 1'b0);
    repeat (16) send_pixel(IN_W'($urandom), 1'b0, 1'b0);

    // Random frames, mostly narrow; some cut short, some widened mid-frame
    sent      = 0;
    fresh_cfg = 1'b1;
    raw_w     = 4;
    while (sent < RANDOM_ITEMS) begin
      if (fresh_cfg) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      raw_w = 4 * $urandom_range(1, 8);
        else if (pick < 70) raw_w = $urandom_range(5, 31);
        else if (pick < 80) raw_w = $urandom_range(0, 3);
        else if (pick < 92) raw_w = $urandom_range(33, 96);
        else                raw_w = 4 * $urandom_range(25, 64);
        write_width(LW_W'(raw_w));
      end
      ew      = eff_line(raw_w);
      lines   = (ew > 64) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      len     = lines * ew + $urandom_range(1, ew);
      grow_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
      cut_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < cut_at; i++) begin
        // widening only, so the upper row always comes from this frame
        if (grow_at != 0 && i == grow_at) begin
          raw_w = ew + 4 * $urandom_range(1, 8);
          if (raw_w > MAX_LINE) raw_w = (1 << LW_W) - 1;
          write_width(LW_W'(raw_w));
          ew = eff_line(raw_w);
        end
        send_pixel(IN_W'($urandom), i == 0,
                   (i == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 15) == 0));
        sent++;
      end
      if (cut_at < len) begin
        // abandoned frame: the next one may restart straight away on the same width
        fresh_cfg = 1'($urandom_range(0, 1));
      end else begin
        fresh_cfg = 1'b1;
        repeat (ew + 1 + $urandom_range(0, 6)) begin
          send_pixel(IN_W'($urandom), 1'b0, 1'b1);
          sent++;
        end
      end
    end

    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/bl5_pkg.sv
rtl/bl5_ifs.sv
rtl/bl5_delay_mem.sv
rtl/bl5_line_mem.sv
rtl/bl5_calc.sv
rtl/bl5_out_fifo.sv
rtl/inplace_five_point_blur_rgb555_top.sv
bench/blur555_checker.sv
bench/testbench.sv
